FILE: src/assert_macros.svh
// Assertion macros used by subset_sum_counter.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

FILE: src/ssc_pkg.sv
package ssc_pkg;

   localparam int VALUE_W  = 18;
   localparam int TARGET_W = 23;
   localparam int COUNT_W  = 16;
   localparam int IDX_MAX_W = 5;   // holds an element index for up to 32 entries

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] match_count;
      logic               overflowed;
   } rsp_type;

   // One Gray code step: which element flips and whether it joins the subset.
   typedef struct packed {
      logic                 add;
      logic [IDX_MAX_W-1:0] idx;
   } flip_type;

   typedef enum logic [2:0] {
      S_LOAD  = 3'b001,
      S_SCAN  = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

endpackage

FILE: src/subset_sum_counter.sv
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+------------------------------------
// request  | start, busy, req_data          | item taken when start & !busy
// response | rsp_valid, rsp_data            | one-cycle strobe, no back-pressure
// config   | csr_wr_en, csr_wr_data         | target written when csr_wr_en
//
// Each item is written to the store as it is taken, unless the store is full.
// After the item marked last, the block walks all 2^N - 1 non-empty subsets
// of the N stored elements in Gray code order, one element-store read and
// one add or subtract per cycle.
// busy stays high from the last item until the result strobe.
// Reset is synchronous and clears the control state; the store needs no clearing.
`include "assert_macros.svh"

module subset_sum_counter
   import ssc_pkg::*;
#(
   parameter int MAX_ITEMS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  logic                       csr_wr_en,
   input  logic signed [TARGET_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int SUM_W = VALUE_W + $clog2(MAX_ITEMS + 1);
   localparam int CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

   // element store: written while loading, read once per enumeration step
   logic [VALUE_W-1:0] elem_mem [MAX_ITEMS];

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic [MAX_ITEMS-1:0]      step_ff, step_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0]        hit_ff, hit_in;
   logic signed [TARGET_W-1:0] target_ff;
   logic                      rd_vld_ff, rd_vld_in;
   logic                      add_ff;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      chk_vld_ff, chk_vld_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff;

   logic                      accept;
   logic                      full;
   logic                      scan_last;
   logic [MAX_ITEMS-1:0]      last_mask;
   logic [IDX_W-1:0]          rd_addr;
   logic signed [CMP_W-1:0]   sum_ext;
   logic signed [CMP_W-1:0]   target_ext;
   logic                      hit;
   flip_type                  flip;

   ssc_gray_step #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_gray_step (
      .step (step_ff),
      .flip (flip)
   );

   assign accept  = start && !busy;
   assign full    = (count_ff == CNT_W'(MAX_ITEMS));
   assign rd_addr = flip.idx[IDX_W-1:0];

   // final Gray step is 2^N - 1: all of the low N bits set
   always_comb begin
      for (int j = 0; j < MAX_ITEMS; j++) begin
         last_mask[j] = (CNT_W'(j) < count_ff);
      end
   end
   assign scan_last = (step_ff == last_mask);

   // compare the registered subset sum against the target
   assign sum_ext    = CMP_W'(sum_ff);
   assign target_ext = CMP_W'(target_ff);
   assign hit        = chk_vld_ff && (sum_ext == target_ext);

   // -- store access --------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept && !full) begin
         elem_mem[count_ff[IDX_W-1:0]] <= req_data.value;
      end
      rd_data_ff <= elem_mem[rd_addr];
      add_ff     <= flip.add;
   end

   // -- control -------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      rd_vld_in    = 1'b0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               // drop the item once the store is full, but remember it
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last) begin
                  step_in  = MAX_ITEMS'(1);
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue one store read per step
            rd_vld_in = 1'b1;
            step_in   = step_ff + MAX_ITEMS'(1);
            if (scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // wait for the add and compare stages to empty
            if (!rd_vld_ff && !chk_vld_ff) begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // -- datapath ------------------------------------------------------------
   always_comb begin
      sum_in     = sum_ff;
      chk_vld_in = rd_vld_ff;
      hit_in     = hit_ff;
      if (state_ff == S_LOAD) begin
         sum_in = '0;
         hit_in = '0;
      end else if (rd_vld_ff) begin
         // advance the running sum by the element that flips
         if (add_ff) begin
            sum_in = sum_ff + SUM_W'(rd_data_ff);
         end else begin
            sum_in = sum_ff - SUM_W'(rd_data_ff);
         end
      end
      // hold the count at its ceiling
      if (hit && (hit_ff != '1)) begin
         hit_in = hit_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= '0;
         sum_ff       <= '0;
         hit_ff       <= '0;
         target_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         hit_ff       <= hit_in;
         rd_vld_ff    <= rd_vld_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

   // capture the result as the drain completes
   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_data_ff.match_count <= hit_ff;
         rsp_data_ff.overflowed  <= ovf_ff;
      end
   end

   assign busy      = (state_ff != S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // -- checks --------------------------------------------------------------
   `ASSERT_CLK(a_rsp_single, clock, reset, rsp_valid_ff |=> !rsp_valid_ff)
   `ASSERT_NEVER(a_pipe_idle_in_load, clock, reset,
                 (state_ff == S_LOAD) && (rd_vld_ff || chk_vld_ff))
   `ASSERT_CLK(a_drop_flags, clock, reset, (accept && full) |=> ovf_ff)

endmodule

FILE: src/ssc_gray_step.sv
module ssc_gray_step
   import ssc_pkg::*;
#(
   parameter int MAX_ITEMS = 16
) (
   input  logic [MAX_ITEMS-1:0] step,
   output flip_type             flip
);

   logic [MAX_ITEMS-1:0] low_bit;
   logic [IDX_MAX_W-1:0] idx;

   // isolate the lowest set bit of the step counter
   assign low_bit = step & (~step + MAX_ITEMS'(1));

   always_comb begin
      idx = '0;
      for (int j = 0; j < MAX_ITEMS; j++) begin
         if (low_bit[j]) begin
            idx = idx | IDX_MAX_W'(j);
         end
      end
   end

   // the Gray bit turns on when the counter bit above the flipped one is clear
   assign flip.add = ~|({low_bit, 1'b0} & {1'b0, step});
   assign flip.idx = idx;

endmodule

FILE: test/subset_sum_counter_tb.sv
`timescale 1ns / 100ps

module subset_sum_counter_tb
   import ssc_pkg::*;
();

   localparam int MAX_HELD      = 16;        // elements the block keeps per sequence
   localparam int SETTLE_CYCLES = 8;         // idle cycles before a target write
   localparam int TAIL_CYCLES   = 8;         // cycles to watch after the last result
   localparam int CYCLE_LIMIT   = 1500000;   // several times the slowest correct run

   // Kinds of entries in the feed: an element, a target write, or a pause
   // that holds the feed until every pending count has come back.
   typedef enum logic [1:0] {
      OP_ITEM   = 2'd0,
      OP_TARGET = 2'd1,
      OP_DRAIN  = 2'd2
   } feed_kind_type;

   typedef struct packed {
      feed_kind_type       kind;
      req_type             item;
      logic [TARGET_W-1:0] target;
      logic [2:0]          gap;
   } feed_op_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       start       = 1'b0;
   req_type                    req_data    = '0;
   logic                       csr_wr_en   = 1'b0;
   logic signed [TARGET_W-1:0] csr_wr_data = '0;
   logic                       busy;
   logic                       rsp_valid;
   rsp_type                    rsp_data;

   subset_sum_counter uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Feed of pending operations and the counts still owed by the block.
   feed_op_type pending_ops[$];
   rsp_type     pending_tallies[$];

   // Shadow of the block: elements of the open sequence and the target.
   logic signed [VALUE_W-1:0]  held_values [0:MAX_HELD-1];
   int                         held_n       = 0;
   logic                       held_dropped = 1'b0;
   logic signed [TARGET_W-1:0] target_now   = '0;

   int planned_items = 0;
   int items_taken   = 0;
   int mismatches    = 0;
   int gap_count     = 0;
   int quiet_cycles  = 0;
   int cycle_count   = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Hold reset at the start, then release it for good.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Absorb one accepted element; on the last one, walk every subset of the
   // held elements, count the sums that hit the target, leave out the empty
   // subset when the target is zero, and owe that count as the next result.
   task automatic tally_item(input req_type it);
      rsp_type owed;
      longint  sum;
      int      hits;
      int      mask;
      int      k;
      if (held_n < MAX_HELD) begin
         held_values[held_n] = it.value;
         held_n++;
      end else begin
         held_dropped = 1'b1;
      end
      if (it.last) begin
         hits = 0;
         for (mask = 0; mask < (1 << held_n); mask++) begin
            sum = 0;
            for (k = 0; k < held_n; k++) begin
               if ((mask >> k) & 1)
                  sum += held_values[k];
            end
            if (sum == target_now)
               hits++;
         end
         if (target_now == 0 && hits > 0)
            hits--;
         owed.match_count = (hits > 65535) ? 16'hFFFF : hits[COUNT_W-1:0];
         owed.overflowed  = held_dropped;
         pending_tallies.push_back(owed);
         held_n       = 0;
         held_dropped = 1'b0;
      end
   endtask

   task automatic queue_item(input logic signed [VALUE_W-1:0] v, input logic l,
                             input int g);
      feed_op_type op;
      op           = '0;
      op.kind      = OP_ITEM;
      op.item.value = v;
      op.item.last = l;
      op.gap       = g[2:0];
      pending_ops.push_back(op);
      planned_items++;
   endtask

   task automatic queue_target(input logic signed [TARGET_W-1:0] t);
      feed_op_type op;
      op        = '0;
      op.kind   = OP_TARGET;
      op.target = t;
      pending_ops.push_back(op);
   endtask

   task automatic queue_drain();
      feed_op_type op;
      op      = '0;
      op.kind = OP_DRAIN;
      pending_ops.push_back(op);
   endtask

   // Mostly small values so that sums collide, with full-range values and
   // the two extremes mixed in.
   function automatic logic signed [VALUE_W-1:0] draw_value();
      int pick;
      int v;
      pick = $urandom_range(0, 19);
      if (pick < 14)
         v = int'($urandom_range(0, 12)) - 6;
      else if (pick < 18)
         v = $urandom;
      else if (pick == 18)
         v = -131072;
      else
         v = 131071;
      return v[VALUE_W-1:0];
   endfunction

   function automatic logic signed [TARGET_W-1:0] draw_target();
      int pick;
      int t;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         t = int'($urandom_range(0, 24)) - 12;
      else if (pick < 8)
         t = $urandom;
      else if (pick == 8)
         t = -4194304;
      else
         t = 4194303;
      return t[TARGET_W-1:0];
   endfunction

   // Fill the feed: a directed opening, then random sequences.
   initial begin
      int seqs;
      int big_seqs;
      int len;
      int pick;
      int i;
      bit calm;

      // Target stays at its reset value of zero for the opening sequences.
      queue_item(18'sd0, 1'b1, $urandom_range(0, 4));         // lone zero
      queue_item(-18'sd131072, 1'b1, $urandom_range(0, 4));   // lone minimum
      queue_item(18'sd131071, 1'b0, 0);                       // extremes and the one cancel
      queue_item(-18'sd131072, 1'b0, 0);
      queue_item(18'sd1, 1'b1, 0);
      // Seventeen zeros: every subset hits, and the last element is dropped.
      for (i = 0; i < 17; i++)
         queue_item(18'sd0, i == 16, (i < 8) ? 0 : $urandom_range(0, 4));
      queue_target(23'sd131071);
      queue_item(18'sd131071, 1'b1, 0);
      queue_target(-23'sd4194304);
      queue_item(-18'sd131072, 1'b1, $urandom_range(0, 4));
      queue_target(23'sd4194303);
      queue_item(18'sd131071, 1'b1, 0);
      queue_drain();

      seqs     = 0;
      big_seqs = 0;
      while (planned_items < 140) begin
         if (seqs % 8 == 0)
            queue_target(draw_target());
         else if (seqs % 7 == 3)
            queue_drain();
         // Keep most sequences short; full and overflowing ones are costly.
         pick = $urandom_range(0, 99);
         if (pick < 3 && big_seqs < 2) begin
            len = $urandom_range(16, 19);
            big_seqs++;
         end else if (pick < 12) begin
            len = $urandom_range(7, 11);
         end else begin
            len = $urandom_range(1, 6);
         end
         calm = ($urandom_range(0, 3) == 0);
         for (i = 0; i < len; i++)
            queue_item(draw_value(), i == len - 1, calm ? 0 : $urandom_range(0, 4));
         seqs++;
      end
   end

   // Driver: wait out each item's gap, hold start until the block takes it,
   // and issue target writes only once the block is idle.
   always @(posedge clock) begin
      feed_op_type op;
      logic        drive_next;
      logic        write_next;
      drive_next = start;
      write_next = 1'b0;
      if (reset) begin
         start     <= 1'b0;
         csr_wr_en <= 1'b0;
         gap_count = 0;
         quiet_cycles = 0;
      end else begin
         if (start && !busy) begin
            tally_item(req_data);
            items_taken++;
            drive_next = 1'b0;
         end
         if (pending_tallies.size() != 0)
            quiet_cycles = 0;
         else if (quiet_cycles < SETTLE_CYCLES)
            quiet_cycles++;
         // Advance the feed only when no item is on the port.
         if (!drive_next && pending_ops.size() != 0) begin
            op = pending_ops[0];
            case (op.kind)
               OP_ITEM: begin
                  if (gap_count < op.gap) begin
                     gap_count++;
                  end else begin
                     void'(pending_ops.pop_front());
                     req_data   <= op.item;
                     drive_next = 1'b1;
                     gap_count  = 0;
                  end
               end
               OP_TARGET: begin
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     void'(pending_ops.pop_front());
                     csr_wr_data <= op.target;
                     write_next = 1'b1;
                     target_now = op.target;
                  end
               end
               OP_DRAIN: begin
                  if (pending_tallies.size() == 0)
                     void'(pending_ops.pop_front());
               end
               default: begin
                  void'(pending_ops.pop_front());
               end
            endcase
         end
         start     <= drive_next;
         csr_wr_en <= write_next;
      end
   end

   // Monitor: compare each strobed result with the oldest owed count.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_tallies.size() == 0) begin
            $error("unexpected result: match_count=%0d overflowed=%0b",
                   rsp_data.match_count, rsp_data.overflowed);
            mismatches++;
         end else begin
            want = pending_tallies.pop_front();
            if (rsp_data.match_count !== want.match_count) begin
               $error("match_count: expected %0d, actual %0d",
                      want.match_count, rsp_data.match_count);
               mismatches++;
            end
            if (rsp_data.overflowed !== want.overflowed) begin
               $error("overflowed: expected %0b, actual %0b",
                      want.overflowed, rsp_data.overflowed);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: drop the run if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Wrap up once every item is taken and every owed count has come back.
   initial begin
      @(negedge clock);
      while (reset || items_taken < planned_items || pending_tallies.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending_tallies.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/ssc_pkg.sv
src/ssc_gray_step.sv
src/subset_sum_counter.sv
test/subset_sum_counter_tb.sv
